[rtl/lramt_pkg.sv]
// ----------------------------------------------------------------------------
// lramt_pkg: shared types and constants of the range-add max tree
// node word layout, controller states, command and status bundles
// ----------------------------------------------------------------------------
package lramt_pkg;

   localparam int LEAVES_DEF  = 1024;
   localparam int LC_REG_W    = 11;
   localparam int IDX_IN_W    = 10;
   localparam int DELTA_W     = 16;
   localparam int MAX_W       = 32;
   localparam int SUM_W       = 48;
   localparam int PEND_W      = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 88;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   // register byte addresses
   localparam logic [PADDR_W-1:0] ADDR_LEAF_COUNT = 3'd0;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [MAX_W-1:0]  max;
      logic [PEND_W-1:0] pend;
   } node_word_type;

   localparam int NODE_WORD_W = SUM_W + MAX_W + PEND_W;

   typedef enum logic [1:0] {
      PH_ENTER,
      PH_RIGHT,
      PH_JOIN
   } phase_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT,
      ST_NODE,
      ST_COVER,
      ST_PD_RD_L,
      ST_PD_WR_L,
      ST_PD_WR_R,
      ST_JOIN_RD_R,
      ST_JOIN_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_init;
      logic clear_step;
      logic start;
      logic load_rsp;
      logic rd_node;
      logic rd_lc;
      logic rd_rc;
      logic mul_cover;
      logic mul_left;
      logic mul_right;
      logic cap_pend;
      logic cap_word;
      logic wr_cover;
      logic wr_lc;
      logic wr_rc;
      logic wr_join;
      logic pop;
      logic push_left;
      logic push_right;
   } dp_cmd_type;

   typedef struct packed {
      logic      clear_last;
      logic      range_ok;
      phase_type phase;
      logic      disjoint;
      logic      covered;
      logic      pend_zero;
      logic      stack_empty;
      logic      rsp_free;
   } dp_status_type;

endpackage

[rtl/lramt_ram.sv]
// ----------------------------------------------------------------------------
// lramt_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lramt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lramt_dp.sv]
// ----------------------------------------------------------------------------
// lramt_dp: datapath of the range-add max tree
// node ram, traversal stack, node add unit, child join, result register
// ----------------------------------------------------------------------------
module lramt_dp #(
   parameter int LEAVES = lramt_pkg::LEAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lramt_pkg::dp_cmd_type               cmd,
   output lramt_pkg::dp_status_type            status,
   input  logic [lramt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [$clog2(LEAVES+1)-1:0]         leaf_count,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lramt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CNT_W  = $clog2(LEAVES + 1);
   localparam int IDX_W  = $clog2(LEAVES);
   localparam int NODES  = 2 * LEAVES;
   localparam int NODE_W = $clog2(NODES);
   localparam int DEPTH  = $clog2(LEAVES) + 1;
   localparam int SP_W   = $clog2(DEPTH);
   localparam int SUM_W  = lramt_pkg::SUM_W;
   localparam int MAX_W  = lramt_pkg::MAX_W;
   localparam int PEND_W = lramt_pkg::PEND_W;
   localparam int PROD_W = PEND_W + CNT_W + 1;
   localparam int ACC_W  = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;
   localparam int PAD_W  = lramt_pkg::RSP_TDATA_W - MAX_W - SUM_W - 1;

   // request fields
   logic [lramt_pkg::IDX_IN_W-1:0]       first_index;
   logic [lramt_pkg::IDX_IN_W-1:0]       last_index;
   logic signed [lramt_pkg::DELTA_W-1:0] delta;

   assign first_index = req_tdata[9:0];
   assign last_index  = req_tdata[19:10];
   assign delta       = req_tdata[35:20];

   logic [IDX_W-1:0] u_ff, v_ff, v_clip;
   logic signed [lramt_pkg::DELTA_W-1:0] delta_ff;
   logic range_ok;

   always_comb begin
      range_ok = (first_index <= last_index) && (32'(first_index) < 32'(leaf_count));
      if (32'(last_index) > 32'(leaf_count) - 32'd1) begin
         v_clip = IDX_W'(leaf_count - CNT_W'(1));
      end else begin
         v_clip = IDX_W'(last_index);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         u_ff     <= IDX_W'(first_index);
         v_ff     <= v_clip;
         delta_ff <= delta;
      end
   end

   // traversal stack, top frame at sp
   logic [NODE_W-1:0]    fr_node_ff [DEPTH];
   logic [IDX_W-1:0]     fr_l_ff    [DEPTH];
   logic [IDX_W-1:0]     fr_r_ff    [DEPTH];
   lramt_pkg::phase_type fr_ph_ff   [DEPTH];
   logic [SP_W-1:0]      sp_ff, sp_in, sp_nx;

   logic [NODE_W-1:0] cur_node, lc_node, rc_node;
   logic [IDX_W-1:0]  cur_l, cur_r, mid;
   logic [IDX_W:0]    lr_sum;
   logic [CNT_W-1:0]  len, left_len, right_len;

   always_comb begin
      cur_node  = fr_node_ff[sp_ff];
      cur_l     = fr_l_ff[sp_ff];
      cur_r     = fr_r_ff[sp_ff];
      lr_sum    = {1'b0, cur_l} + {1'b0, cur_r};
      mid       = lr_sum[IDX_W:1];
      len       = CNT_W'(cur_r - cur_l) + CNT_W'(1);
      left_len  = CNT_W'(mid - cur_l) + CNT_W'(1);
      right_len = CNT_W'(cur_r - mid);
      lc_node   = cur_node + NODE_W'(1);
      rc_node   = cur_node + NODE_W'({left_len, 1'b0});
      sp_nx     = sp_ff + SP_W'(1);
   end

   always_comb begin
      sp_in = sp_ff;
      priority if (cmd.start) begin
         sp_in = '0;
      end else if (cmd.push_left || cmd.push_right) begin
         sp_in = sp_nx;
      end else if (cmd.pop && (sp_ff != '0)) begin
         sp_in = sp_ff - SP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         fr_node_ff[0] <= '0;
         fr_l_ff[0]    <= '0;
         fr_r_ff[0]    <= IDX_W'(leaf_count - CNT_W'(1));
         fr_ph_ff[0]   <= lramt_pkg::PH_ENTER;
      end
      if (cmd.push_left) begin
         fr_ph_ff[sp_ff]   <= lramt_pkg::PH_RIGHT;
         fr_node_ff[sp_nx] <= lc_node;
         fr_l_ff[sp_nx]    <= cur_l;
         fr_r_ff[sp_nx]    <= mid;
         fr_ph_ff[sp_nx]   <= lramt_pkg::PH_ENTER;
      end
      if (cmd.push_right) begin
         fr_ph_ff[sp_ff]   <= lramt_pkg::PH_JOIN;
         fr_node_ff[sp_nx] <= rc_node;
         fr_l_ff[sp_nx]    <= mid + IDX_W'(1);
         fr_r_ff[sp_nx]    <= cur_r;
         fr_ph_ff[sp_nx]   <= lramt_pkg::PH_ENTER;
      end
   end

   // node ram
   lramt_pkg::node_word_type rd_word, wr_word, word_ff;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   logic              wr_en, rd_en;
   logic [NODE_W-1:0] clr_ff, clr_in;

   lramt_ram #(
      .WIDTH (lramt_pkg::NODE_WORD_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // multiply stage of the node add
   logic signed [PEND_W-1:0] mul_d, d_ff, pend_ff;
   logic [CNT_W-1:0]         mul_len;
   logic signed [ACC_W-1:0]  prod_in, prod_ff;
   logic                     multi_ff;

   always_comb begin
      mul_d   = cmd.mul_cover ? PEND_W'(delta_ff) : pend_ff;
      mul_len = cmd.mul_cover ? len : (cmd.mul_left ? left_len : right_len);
      prod_in = ACC_W'(mul_d) * ACC_W'($signed({1'b0, mul_len}));
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_cover || cmd.mul_left || cmd.mul_right) begin
         prod_ff  <= prod_in;
         d_ff     <= mul_d;
         multi_ff <= (mul_len > CNT_W'(1));
      end
      if (cmd.cap_pend) begin
         pend_ff <= $signed(rd_word.pend);
      end
      if (cmd.cap_word) begin
         word_ff <= rd_word;
      end
   end

   // node add: sum += len*d, max += d, pending += d when the node spans more than one leaf
   lramt_pkg::node_word_type add_word, join_word;
   logic signed [ACC_W-1:0] add_sum;
   logic [MAX_W:0]          add_max;
   logic                    add_ovf;
   logic [SUM_W:0]          join_sum;
   logic                    join_ovf;

   always_comb begin
      add_sum  = ACC_W'($signed(rd_word.sum)) + prod_ff;
      add_max  = {rd_word.max[MAX_W-1], rd_word.max} + {d_ff[PEND_W-1], d_ff};
      add_ovf  = !((&add_sum[ACC_W-1:SUM_W-1]) || !(|add_sum[ACC_W-1:SUM_W-1]))
                 || (add_max[MAX_W] != add_max[MAX_W-1]);
      add_word.sum  = add_sum[SUM_W-1:0];
      add_word.max  = add_max[MAX_W-1:0];
      add_word.pend = multi_ff ? (rd_word.pend + d_ff) : rd_word.pend;

      // left child held in word_ff, right child on the read port
      join_sum = {word_ff.sum[SUM_W-1], word_ff.sum} + {rd_word.sum[SUM_W-1], rd_word.sum};
      join_ovf = join_sum[SUM_W] != join_sum[SUM_W-1];
      join_word.sum  = join_sum[SUM_W-1:0];
      join_word.max  = ($signed(word_ff.max) > $signed(rd_word.max)) ? word_ff.max
                                                                      : rd_word.max;
      join_word.pend = '0;
   end

   always_comb begin
      wr_en = cmd.clear_step || cmd.wr_cover || cmd.wr_lc || cmd.wr_rc || cmd.wr_join;
      priority if (cmd.clear_step) begin
         wr_addr = clr_ff;
         wr_word = '0;
      end else if (cmd.wr_join) begin
         wr_addr = cur_node;
         wr_word = join_word;
      end else if (cmd.wr_lc) begin
         wr_addr = lc_node;
         wr_word = add_word;
      end else if (cmd.wr_rc) begin
         wr_addr = rc_node;
         wr_word = add_word;
      end else begin
         wr_addr = cur_node;
         wr_word = add_word;
      end
      rd_en = cmd.rd_node || cmd.rd_lc || cmd.rd_rc;
      priority if (cmd.rd_lc) begin
         rd_addr = lc_node;
      end else if (cmd.rd_rc) begin
         rd_addr = rc_node;
      end else begin
         rd_addr = cur_node;
      end
   end

   // clear sweep address
   always_comb begin
      clr_in = clr_ff;
      priority if (cmd.clear_init) begin
         clr_in = '0;
      end else if (cmd.clear_step) begin
         clr_in = clr_ff + NODE_W'(1);
      end
   end

   // sticky overflow and copy of the root node
   logic ovf_ff, ovf_in;
   logic [SUM_W-1:0] root_sum_ff;
   logic [MAX_W-1:0] root_max_ff;

   assign ovf_in = ovf_ff
                   || ((cmd.wr_cover || cmd.wr_lc || cmd.wr_rc) && add_ovf)
                   || (cmd.wr_join && join_ovf);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         root_sum_ff <= wr_word.sum;
         root_max_ff <= wr_word.max;
      end
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [lramt_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {PAD_W'(0), ovf_ff, root_sum_ff, root_max_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.clear_last  = (clr_ff == NODE_W'(NODES - 1));
      status.range_ok    = range_ok;
      status.phase       = fr_ph_ff[sp_ff];
      status.disjoint    = (cur_r < u_ff) || (v_ff < cur_l);
      status.covered     = (u_ff <= cur_l) && (cur_r <= v_ff);
      status.pend_zero   = (rd_word.pend == '0);
      status.stack_empty = (sp_ff == '0);
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

endmodule

[rtl/lramt_ctrl.sv]
// ----------------------------------------------------------------------------
// lramt_ctrl: sequencer of the range-add max tree
// clear sweep, stack walk, push-down, join and result hand-off
// ----------------------------------------------------------------------------
module lramt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     cfg_wr,
   input  lramt_pkg::dp_status_type status,
   output lramt_pkg::dp_cmd_type    cmd
);

   lramt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lramt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lramt_pkg::ST_CLEAR: begin
            if (!cfg_wr && status.clear_last) state_in = lramt_pkg::ST_IDLE;
         end
         lramt_pkg::ST_IDLE: begin
            if (cfg_wr) begin
               state_in = lramt_pkg::ST_CLEAR;
            end else if (req_tvalid) begin
               state_in = status.range_ok ? lramt_pkg::ST_VISIT : lramt_pkg::ST_DONE;
            end
         end
         lramt_pkg::ST_VISIT: begin
            unique case (status.phase)
               lramt_pkg::PH_ENTER: begin
                  if (!status.disjoint) begin
                     state_in = lramt_pkg::ST_NODE;
                  end else if (status.stack_empty) begin
                     state_in = lramt_pkg::ST_DONE;
                  end
               end
               lramt_pkg::PH_RIGHT: state_in = lramt_pkg::ST_VISIT;
               lramt_pkg::PH_JOIN:  state_in = lramt_pkg::ST_JOIN_RD_R;
               default:             state_in = lramt_pkg::ST_VISIT;
            endcase
         end
         lramt_pkg::ST_NODE: begin
            priority if (status.covered) begin
               state_in = lramt_pkg::ST_COVER;
            end else if (status.pend_zero) begin
               state_in = lramt_pkg::ST_VISIT;
            end else begin
               state_in = lramt_pkg::ST_PD_RD_L;
            end
         end
         lramt_pkg::ST_COVER, lramt_pkg::ST_JOIN_WR: begin
            state_in = status.stack_empty ? lramt_pkg::ST_DONE : lramt_pkg::ST_VISIT;
         end
         lramt_pkg::ST_PD_RD_L:   state_in = lramt_pkg::ST_PD_WR_L;
         lramt_pkg::ST_PD_WR_L:   state_in = lramt_pkg::ST_PD_WR_R;
         lramt_pkg::ST_PD_WR_R:   state_in = lramt_pkg::ST_VISIT;
         lramt_pkg::ST_JOIN_RD_R: state_in = lramt_pkg::ST_JOIN_WR;
         lramt_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = lramt_pkg::ST_IDLE;
         end
         default: state_in = lramt_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lramt_pkg::ST_CLEAR: begin
            cmd.clear_init = cfg_wr;
            cmd.clear_step = !cfg_wr;
         end
         lramt_pkg::ST_IDLE: begin
            req_tready     = !cfg_wr;
            cmd.clear_init = cfg_wr;
            cmd.start      = !cfg_wr && req_tvalid;
         end
         lramt_pkg::ST_VISIT: begin
            unique case (status.phase)
               lramt_pkg::PH_ENTER: begin
                  cmd.pop     = status.disjoint;
                  cmd.rd_node = !status.disjoint;
               end
               lramt_pkg::PH_RIGHT: cmd.push_right = 1'b1;
               lramt_pkg::PH_JOIN:  cmd.rd_lc      = 1'b1;
               default:             cmd.pop        = 1'b0;
            endcase
         end
         lramt_pkg::ST_NODE: begin
            cmd.mul_cover = status.covered;
            cmd.push_left = !status.covered && status.pend_zero;
            cmd.cap_pend  = !status.covered && !status.pend_zero;
         end
         lramt_pkg::ST_COVER: begin
            cmd.wr_cover = 1'b1;
            cmd.pop      = 1'b1;
         end
         lramt_pkg::ST_PD_RD_L: begin
            cmd.rd_lc    = 1'b1;
            cmd.mul_left = 1'b1;
         end
         lramt_pkg::ST_PD_WR_L: begin
            cmd.wr_lc     = 1'b1;
            cmd.rd_rc     = 1'b1;
            cmd.mul_right = 1'b1;
         end
         lramt_pkg::ST_PD_WR_R: begin
            cmd.wr_rc     = 1'b1;
            cmd.push_left = 1'b1;
         end
         lramt_pkg::ST_JOIN_RD_R: begin
            cmd.cap_word = 1'b1;
            cmd.rd_rc    = 1'b1;
         end
         lramt_pkg::ST_JOIN_WR: begin
            cmd.wr_join = 1'b1;
            cmd.pop     = 1'b1;
         end
         lramt_pkg::ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/lazy_range_add_max_tree_unit.sv]
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree_unit: range add on a lazy segment tree, max and sum
// walk: a node outside the range is popped, a covered node takes the add, a split
//   node is entered and later joined, and its pending add is first pushed to the
//   children; an empty or out-of-range item skips the walk, and the result
//   waits until the receiver takes it
// throughput: one item at a time; the serial node ram walk sets the rate
// reset: synchronous, active high; then a clear sweep zeroes every node, and a
//   leaf_count write in the idle or clear state starts the same sweep again
// ----------------------------------------------------------------------------
module lazy_range_add_max_tree_unit #(
   parameter int LEAVES = lramt_pkg::LEAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // first_index[9:0], last_index[19:10], delta[35:20], zero pad
   input  logic [lramt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // max_value[31:0], total_sum[79:32], overflow_flag[80], zero pad
   output logic [lramt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lramt_pkg::PADDR_W-1:0]       paddr,
   input  logic [lramt_pkg::PDATA_W-1:0]       pwdata,
   output logic [lramt_pkg::PDATA_W-1:0]       prdata,
   output logic                                pready
);

   localparam int CNT_W    = $clog2(LEAVES + 1);
   localparam int LC_RESET = (LEAVES < 1024) ? LEAVES : 1024;

   // register write strobe, only leaf_count is decoded
   logic cfg_wr;
   logic [lramt_pkg::LC_REG_W-1:0] wr_val;
   logic [CNT_W-1:0] leaf_count_ff, leaf_count_in, lc_sat;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr == lramt_pkg::ADDR_LEAF_COUNT);
   assign wr_val = pwdata[lramt_pkg::LC_REG_W-1:0];

   // zero reads as one, above the tree size saturates
   always_comb begin
      priority if (wr_val == '0) begin
         lc_sat = CNT_W'(1);
      end else if (32'(wr_val) > 32'(LEAVES)) begin
         lc_sat = CNT_W'(LEAVES);
      end else begin
         lc_sat = CNT_W'(wr_val);
      end
      leaf_count_in = cfg_wr ? lc_sat : leaf_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= CNT_W'(LC_RESET);
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   assign prdata = (paddr == lramt_pkg::ADDR_LEAF_COUNT) ? lramt_pkg::PDATA_W'(leaf_count_ff)
                                                         : '0;

   lramt_pkg::dp_cmd_type    cmd;
   lramt_pkg::dp_status_type status;

   // sequencer: owns the state machine and the handshake toward the input
   lramt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cfg_wr     (cfg_wr),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: node ram, traversal stack, arithmetic and result register
   lramt_dp #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .leaf_count (leaf_count_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // an accepted item closes the input in the next cycle
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after an item");

   // a leaf_count write while idle or clearing starts the clear sweep
   a_clear_after_cfg: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_tready)
      else $error("input open during clear sweep");

   // a new result only appears as the walk finishes
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result loaded while idle");

endmodule

[tb/sv/lazy_range_add_max_tree_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree_unit_tb: self-checking bench for the range-add tree
// drives range-add items over the stream port, predicts root max, total sum
// and the sticky overflow flag with a behavioral lazy tree, and checks each
// result item in order; leaf_count is reprogrammed between phases
// ----------------------------------------------------------------------------
module lazy_range_add_max_tree_unit_tb;

   localparam int LEAVES_DEF  = lramt_pkg::LEAVES_DEF;
   localparam int MAX_W       = lramt_pkg::MAX_W;
   localparam int SUM_W       = lramt_pkg::SUM_W;
   localparam int PEND_W      = lramt_pkg::PEND_W;
   localparam int LC_REG_W    = lramt_pkg::LC_REG_W;
   localparam int IDX_IN_W    = lramt_pkg::IDX_IN_W;
   localparam int DELTA_W     = lramt_pkg::DELTA_W;
   localparam int REQ_TDATA_W = lramt_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = lramt_pkg::RSP_TDATA_W;
   localparam int PADDR_W     = lramt_pkg::PADDR_W;
   localparam int PDATA_W     = lramt_pkg::PDATA_W;
   localparam int NODE_CNT    = 2 * LEAVES_DEF;

   // expected result of one range add
   typedef struct {
      logic [MAX_W-1:0] max_value;
      logic [SUM_W-1:0] total_sum;
      logic             overflow_flag;
   } tree_result_type;

   // behavioral lazy tree plus the queue of results still owed by the block
   class tree_scoreboard;
      logic [SUM_W-1:0]  sum_mem[NODE_CNT];
      logic [MAX_W-1:0]  max_mem[NODE_CNT];
      logic [PEND_W-1:0] pend_mem[NODE_CNT];
      bit                ovf_seen;
      int unsigned       leaves_used;
      tree_result_type   pending_results[$];
      int                mismatch_count;

      function void clear_nodes();
         foreach (sum_mem[i]) begin
            sum_mem[i] = '0;
            max_mem[i] = '0;
            pend_mem[i] = '0;
         end
      endfunction

      function void power_up();
         clear_nodes();
         ovf_seen = 0;
         leaves_used = LEAVES_DEF;
         mismatch_count = 0;
      endfunction

      function void set_leaf_count(logic [LC_REG_W-1:0] value);
         int unsigned v;
         v = 32'(value);
         if (v == 0) v = 1;
         if (v > LEAVES_DEF) v = LEAVES_DEF;
         leaves_used = v;
         clear_nodes();
      endfunction

      // 48-bit and 32-bit writes that flag a wrap
      function logic [SUM_W-1:0] wrap48(longint s);
         if (s < -(64'sd1 <<< 47) || s >= (64'sd1 <<< 47)) ovf_seen = 1;
         return s[SUM_W-1:0];
      endfunction

      function logic [MAX_W-1:0] wrap32(longint m);
         if (m < -(64'sd1 <<< 31) || m >= (64'sd1 <<< 31)) ovf_seen = 1;
         return m[MAX_W-1:0];
      endfunction

      function void apply_add(int unsigned n, int unsigned len, longint d);
         sum_mem[n] = wrap48(longint'($signed(sum_mem[n])) + longint'(len) * d);
         max_mem[n] = wrap32(longint'($signed(max_mem[n])) + d);
         if (len > 1) pend_mem[n] = pend_mem[n] + d[31:0];
      endfunction

      function void push_pending(int unsigned n, int unsigned l, int unsigned r);
         int unsigned mid;
         longint d;
         if (l == r || pend_mem[n] == 0) return;
         mid = (l + r) / 2;
         d = longint'($signed(pend_mem[n]));
         apply_add(n + 1, mid - l + 1, d);
         apply_add(n + 2 * (mid - l + 1), r - mid, d);
         pend_mem[n] = '0;
      endfunction

      function automatic void range_add(int unsigned n, int unsigned l, int unsigned r,
                                        int unsigned u, int unsigned v, longint d);
         int unsigned mid, lc, rc;
         longint a, b;
         if (n >= NODE_CNT || r < u || v < l) return;
         if (u <= l && r <= v) begin
            apply_add(n, r - l + 1, d);
            return;
         end
         push_pending(n, l, r);
         mid = (l + r) / 2;
         lc = n + 1;
         rc = n + 2 * (mid - l + 1);
         range_add(lc, l, mid, u, v, d);
         range_add(rc, mid + 1, r, u, v, d);
         sum_mem[n] = wrap48(longint'($signed(sum_mem[lc])) + longint'($signed(sum_mem[rc])));
         a = longint'($signed(max_mem[lc]));
         b = longint'($signed(max_mem[rc]));
         max_mem[n] = (a > b) ? a[31:0] : b[31:0];
      endfunction

      // note an accepted item and queue its result
      function void note_item(logic [IDX_IN_W-1:0] first_idx, logic [IDX_IN_W-1:0] last_idx,
                              logic [DELTA_W-1:0] delta);
         int unsigned u, v;
         tree_result_type res;
         u = 32'(first_idx);
         v = 32'(last_idx);
         if (u <= v && u < leaves_used) begin
            if (v > leaves_used - 1) v = leaves_used - 1;
            range_add(0, 0, leaves_used - 1, u, v, longint'($signed(delta)));
         end
         res.max_value = max_mem[0];
         res.total_sum = sum_mem[0];
         res.overflow_flag = ovf_seen;
         pending_results = {pending_results, res};
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data);
         tree_result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: %h", data);
            mismatch_count++;
            return;
         end
         exp_res = pending_results.pop_front();
         if (data[31:0] !== exp_res.max_value) begin
            $error("max_value expected %h actual %h", exp_res.max_value, data[31:0]);
            mismatch_count++;
         end
         if (data[79:32] !== exp_res.total_sum) begin
            $error("total_sum expected %h actual %h", exp_res.total_sum, data[79:32]);
            mismatch_count++;
         end
         if (data[80] !== exp_res.overflow_flag) begin
            $error("overflow_flag expected %b actual %b", exp_res.overflow_flag, data[80]);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   // first_index[9:0], last_index[19:10], delta[35:20], zero pad
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic                     req_tvalid = 0;
   logic                     req_tready;
   // max_value[31:0], total_sum[79:32], overflow_flag[80], zero pad
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 0;
   logic                     psel = 0;
   logic                     penable = 0;
   logic                     pwrite = 0;
   logic [PADDR_W-1:0]       paddr = '0;
   logic [PDATA_W-1:0]       pwdata = '0;
   logic [PDATA_W-1:0]       prdata;
   logic                     pready;

   tree_scoreboard tree_model = new();
   bit             calm_mode = 0;     // no idling on either side
   bit             hold_rsp = 0;      // long receiver hold-off

   always #5 clock = ~clock;

   lazy_range_add_max_tree_unit uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // receiver: random stalls, a long hold when asked, checks on each accepted item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tree_model.check_result(rsp_tdata);
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 8);
   end

   // send one item; idle gaps before it at random
   task automatic send_item(logic [IDX_IN_W-1:0] first_idx, logic [IDX_IN_W-1:0] last_idx,
                            logic [DELTA_W-1:0] delta);
      while (!calm_mode && $urandom_range(99) < 8) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tdata <= {4'b0, delta, last_idx, first_idx};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      tree_model.note_item(first_idx, last_idx, delta);
   endtask

   task automatic end_burst();
      req_tvalid <= 0;
   endtask

   // wait for the block to drain, then let it settle back to idle
   task automatic drain();
      end_burst();
      while (tree_model.pending_results.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_leaf_count(logic [LC_REG_W-1:0] value);
      drain();
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= lramt_pkg::ADDR_LEAF_COUNT;
      pwdata <= PDATA_W'(value);
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      tree_model.set_leaf_count(value);
      // clear sweep after the write; requests simply stall until it finishes
   endtask

   // mostly small ranges, some wide ones, and occasional empty or stray ones
   task automatic random_items(int unsigned count, int unsigned lc);
      logic [IDX_IN_W-1:0] a, b;
      logic [DELTA_W-1:0]  d;
      int unsigned         sel;
      int unsigned         span;
      repeat (count) begin
         sel = $urandom_range(99);
         span = $urandom_range(7);
         a = IDX_IN_W'($urandom_range(lc - 1));
         if (sel < 60) b = IDX_IN_W'((32'(a) + span > lc - 1) ? lc - 1 : 32'(a) + span);
         else if (sel < 85) b = IDX_IN_W'($urandom_range(lc - 1, 32'(a)));
         else b = IDX_IN_W'($urandom);
         if (sel >= 95) a = IDX_IN_W'($urandom);
         d = DELTA_W'($urandom);
         send_item(a, b, d);
      end
   endtask

   initial begin
      tree_model.power_up();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, empty range, range past end, partial clip, whole tree
      send_item(10'd0, 10'd1023, 16'h7fff);
      send_item(10'd0, 10'd0, 16'h8000);
      send_item(10'd1023, 10'd1023, 16'h7fff);
      send_item(10'd5, 10'd4, 16'h1234);
      send_item(10'd512, 10'd1023, 16'hffff);
      send_item(10'd3, 10'd700, 16'h0001);
      send_item(10'd1023, 10'd0, 16'h8000);
      send_item(10'd10, 10'd10, 16'h0000);
      end_burst();
      write_leaf_count(11'd7);
      send_item(10'd7, 10'd9, 16'h4000);
      send_item(10'd2, 10'd1023, 16'h0100);
      send_item(10'd0, 10'd6, 16'h8000);
      send_item(10'd1, 10'd1, 16'h7fff);
      end_burst();
      write_leaf_count(11'd0);
      send_item(10'd0, 10'd0, 16'h7fff);
      send_item(10'd1, 10'd1, 16'h7fff);
      send_item(10'd0, 10'd1023, 16'h8000);
      end_burst();
      write_leaf_count(11'd2047);
      // many whole-tree maximum adds in a row raise the sum and the max
      calm_mode = 1;
      repeat (20) send_item(10'd0, 10'd1023, 16'h7fff);
      calm_mode = 0;

      // back-pressure: receiver holds while the sender keeps offering items
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         random_items(30, 1024);
      join

      random_items(400, 1024);
      write_leaf_count(11'd1);
      random_items(100, 1);
      write_leaf_count(11'd2);
      random_items(150, 2);
      write_leaf_count(11'd37);
      calm_mode = 1;
      random_items(200, 37);
      calm_mode = 0;
      random_items(150, 37);
      write_leaf_count(11'd1024);
      random_items(400, 1024);
      write_leaf_count(11'd300);
      random_items(400, 300);
      drain();

      if (tree_model.mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

[sim.f]
rtl/lramt_pkg.sv
rtl/lramt_ram.sv
rtl/lramt_dp.sv
rtl/lramt_ctrl.sv
rtl/lazy_range_add_max_tree_unit.sv
tb/sv/lazy_range_add_max_tree_unit_tb.sv
